// ----- design/lzg_pkg.sv -----
// Package for the LZ gamma stream decompressor: parse phases, sequencer
// states and shared constants. No dependencies.
package lzg_pkg;

   localparam int WindowBytes = 65536;
   localparam int PtrW = $clog2(WindowBytes);
   localparam int OffW = PtrW + 1;
   localparam logic [31:0] EndMark = 32'd512;

   typedef enum logic [3:0] {
      PH_LITLEN_STOP = 4'd0,
      PH_LITLEN_DATA = 4'd1,
      PH_LITERAL     = 4'd2,
      PH_AFTER_LIT   = 4'd3,
      PH_CMD         = 4'd4,
      PH_OFFHI_STOP  = 4'd5,
      PH_OFFHI_DATA  = 4'd6,
      PH_OFFLO       = 4'd7,
      PH_MLEN_STOP   = 4'd8,
      PH_MLEN_DATA   = 4'd9,
      PH_REP_STOP    = 4'd10,
      PH_REP_DATA    = 4'd11,
      PH_COPY        = 4'd12,
      PH_DONE        = 4'd13,
      PH_ERROR       = 4'd14
   } phase_type;

   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_BITS,
      SQ_READ,
      SQ_COPY,
      SQ_OUT
   } seq_type;

   localparam logic [1:0] KIND_DATA = 2'd0;
   localparam logic [1:0] KIND_NONE = 2'd1;
   localparam logic [1:0] KIND_REJ  = 2'd2;

   localparam logic [1:0] ST_NEED  = 2'd0;
   localparam logic [1:0] ST_COPY  = 2'd1;
   localparam logic [1:0] ST_DONE  = 2'd2;
   localparam logic [1:0] ST_ERROR = 2'd3;

   localparam logic CMD_BYTE  = 1'b0;
   localparam logic CMD_DRAIN = 1'b1;

endpackage

// ----- design/lz_gamma_stream_decompressor.sv -----
// Top level of the LZ gamma stream decompressor: sequencer, bit decoder,
// 64 KiB history memory and output register. Uses lzg_pkg.
//
// Path (accept to response valid): a rejected request goes straight to output;
// literal, offset and flag bytes pass the bit state, which decodes a flag byte's
// bits (up to 8); a drain tick goes through read, copy and bit states (history
// read is registered); a literal/offset byte or a drain ending a copy also decodes leftover flag bits (up to 7).
// Throughput: one request in flight; req_ready is low while a request is
// worked on or its response waits, and returns the cycle after the response
// is taken. Synchronous active-high reset; history is not reset.
module lz_gamma_stream_decompressor
   import lzg_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_cmd,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_out_byte,
   output logic [1:0] rsp_status
);

   // architectural state
   phase_type        phase_ff, phase_in;
   logic [7:0]       bitbuf_ff, bitbuf_in;
   logic [3:0]       bits_ff, bits_in;
   logic [31:0]      gamma_ff, gamma_in;
   logic [31:0]      lits_ff, lits_in;
   logic [OffW-1:0]  lastoff_ff, lastoff_in;
   logic [31:0]      copy_ff, copy_in;
   logic [PtrW-1:0]  wptr_ff, wptr_in;
   // sequencer
   seq_type          seq_ff, seq_in;
   logic [1:0]       kind_ff, kind_in;
   logic [7:0]       obyte_ff, obyte_in;

   logic [7:0]       hist [WindowBytes];
   logic [7:0]       rdata_ff;
   logic             hwe;
   logic [7:0]       hwdata;
   logic [PtrW-1:0]  raddr;

   logic             accept;
   logic             rsp_take;
   logic [1:0]       st_now;

   assign accept    = req_valid && req_ready;
   assign rsp_take  = rsp_valid && rsp_ready;
   assign req_ready = (seq_ff == SQ_IDLE);
   assign rsp_valid = (seq_ff == SQ_OUT);

   // copy source: wptr - offset modulo the window (offset already checked)
   assign raddr = wptr_ff - lastoff_ff[PtrW-1:0];

   always_ff @(posedge clock) begin
      if (hwe) begin
         hist[wptr_ff] <= hwdata;
      end
      rdata_ff <= hist[raddr];
   end

   function automatic logic is_bit_phase(input phase_type p);
      return (p <= PH_REP_DATA) && (p != PH_LITERAL) && (p != PH_OFFLO);
   endfunction

   // gamma base: 0 stands for the start value 1
   logic [31:0] gbase;
   logic        bit_now;
   logic [38:0] off_full;
   assign gbase   = (gamma_ff == 32'd0) ? 32'd1 : gamma_ff;
   assign bit_now = bitbuf_ff[7];
   assign off_full = {gamma_ff, 7'h7f - req_in_byte[7:1]} + 39'd1;

   // next-state sequencer
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               seq_in = SQ_OUT;
               if (phase_ff != PH_DONE && phase_ff != PH_ERROR) begin
                  if (req_cmd == CMD_DRAIN && phase_ff == PH_COPY) begin
                     seq_in = SQ_READ;
                  end else if (req_cmd == CMD_BYTE && phase_ff != PH_COPY) begin
                     seq_in = SQ_BITS;
                  end
               end
            end
         end
         SQ_READ: seq_in = SQ_COPY;
         SQ_COPY: seq_in = SQ_BITS;
         SQ_BITS: begin
            if (!(is_bit_phase(phase_ff) && bits_ff != 4'd0)) begin
               seq_in = SQ_OUT;
            end
         end
         SQ_OUT: begin
            if (rsp_take) begin
               seq_in = SQ_IDLE;
            end
         end
         default: seq_in = SQ_IDLE;
      endcase
   end

   // datapath actions
   always_comb begin
      phase_in   = phase_ff;
      bitbuf_in  = bitbuf_ff;
      bits_in    = bits_ff;
      gamma_in   = gamma_ff;
      lits_in    = lits_ff;
      lastoff_in = lastoff_ff;
      copy_in    = copy_ff;
      wptr_in    = wptr_ff;
      kind_in    = kind_ff;
      obyte_in   = obyte_ff;
      hwe        = 1'b0;
      hwdata     = req_in_byte;
      case (seq_ff)
         SQ_IDLE: begin
            if (accept) begin
               kind_in  = KIND_NONE;
               obyte_in = 8'd0;
               if (phase_ff == PH_DONE || phase_ff == PH_ERROR ||
                   (req_cmd == CMD_DRAIN && phase_ff != PH_COPY) ||
                   (req_cmd == CMD_BYTE && phase_ff == PH_COPY)) begin
                  kind_in = KIND_REJ;
               end else if (req_cmd == CMD_BYTE) begin
                  if (phase_ff == PH_LITERAL) begin
                     obyte_in = req_in_byte;
                     kind_in  = KIND_DATA;
                     hwe      = 1'b1;
                     wptr_in  = wptr_ff + 1'b1;
                     lits_in  = lits_ff - 32'd1;
                     if (lits_ff == 32'd1) begin
                        phase_in = PH_AFTER_LIT;
                     end
                  end else if (phase_ff == PH_OFFLO) begin
                     gamma_in = 32'd0;
                     if (off_full > 39'(WindowBytes)) begin
                        phase_in = PH_ERROR;
                     end else begin
                        lastoff_in = off_full[OffW-1:0];
                        if (req_in_byte[0]) begin
                           copy_in  = 32'd2;
                           phase_in = PH_COPY;
                        end else begin
                           phase_in = PH_MLEN_DATA;
                        end
                     end
                  end else begin
                     bitbuf_in = req_in_byte;
                     bits_in   = 4'd8;
                  end
               end
            end
         end
         SQ_COPY: begin
            obyte_in = rdata_ff;
            kind_in  = KIND_DATA;
            hwe      = 1'b1;
            hwdata   = rdata_ff;
            wptr_in  = wptr_ff + 1'b1;
            copy_in  = copy_ff - 32'd1;
            if (copy_ff == 32'd1) begin
               phase_in = PH_CMD;
            end
         end
         SQ_BITS: begin
            if (is_bit_phase(phase_ff) && bits_ff != 4'd0) begin
               bitbuf_in = {bitbuf_ff[6:0], 1'b0};
               bits_in   = bits_ff - 4'd1;
               case (phase_ff)
                  PH_LITLEN_STOP: begin
                     if (bit_now) begin
                        lits_in  = gbase;
                        gamma_in = 32'd0;
                        phase_in = PH_LITERAL;
                     end else begin
                        phase_in = PH_LITLEN_DATA;
                     end
                  end
                  PH_AFTER_LIT: phase_in = bit_now ? PH_OFFHI_STOP : PH_REP_STOP;
                  PH_CMD:       phase_in = bit_now ? PH_OFFHI_STOP : PH_LITLEN_STOP;
                  PH_OFFHI_STOP: begin
                     if (bit_now) begin
                        if (gbase == EndMark) begin
                           gamma_in = 32'd0;
                           phase_in = PH_DONE;
                        end else begin
                           gamma_in = gbase - 32'd1;
                           phase_in = PH_OFFLO;
                        end
                     end else begin
                        phase_in = PH_OFFHI_DATA;
                     end
                  end
                  PH_MLEN_STOP: begin
                     if (bit_now) begin
                        gamma_in = 32'd0;
                        if (gbase == 32'hffff_ffff) begin
                           phase_in = PH_ERROR;
                        end else begin
                           copy_in  = gbase + 32'd1;
                           phase_in = PH_COPY;
                        end
                     end else begin
                        phase_in = PH_MLEN_DATA;
                     end
                  end
                  PH_REP_STOP: begin
                     if (bit_now) begin
                        copy_in  = gbase;
                        gamma_in = 32'd0;
                        phase_in = PH_COPY;
                     end else begin
                        phase_in = PH_REP_DATA;
                     end
                  end
                  PH_LITLEN_DATA, PH_OFFHI_DATA, PH_MLEN_DATA, PH_REP_DATA: begin
                     // shared gamma shift unit
                     if (gbase[31]) begin
                        phase_in = PH_ERROR;
                     end else begin
                        gamma_in = {gbase[30:0], bit_now};
                        phase_in = phase_type'(phase_ff - 4'd1);
                     end
                  end
                  default: phase_in = phase_ff;
               endcase
            end
         end
         default: ;
      endcase
   end

   always_comb begin
      case (phase_ff)
         PH_DONE:  st_now = ST_DONE;
         PH_COPY:  st_now = ST_COPY;
         PH_ERROR: st_now = ST_ERROR;
         default:  st_now = (phase_ff > PH_ERROR) ? ST_ERROR : ST_NEED;
      endcase
   end

   assign rsp_kind     = kind_ff;
   assign rsp_out_byte = obyte_ff;
   assign rsp_status   = st_now;

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff     <= SQ_IDLE;
         phase_ff   <= PH_LITLEN_STOP;
         bitbuf_ff  <= 8'd0;
         bits_ff    <= 4'd0;
         gamma_ff   <= 32'd0;
         lits_ff    <= 32'd0;
         lastoff_ff <= OffW'(1);
         copy_ff    <= 32'd0;
         wptr_ff    <= '0;
      end else begin
         seq_ff     <= seq_in;
         phase_ff   <= phase_in;
         bitbuf_ff  <= bitbuf_in;
         bits_ff    <= bits_in;
         gamma_ff   <= gamma_in;
         lits_ff    <= lits_in;
         lastoff_ff <= lastoff_in;
         copy_ff    <= copy_in;
         wptr_ff    <= wptr_in;
      end
      kind_ff  <= kind_in;
      obyte_ff <= obyte_in;
   end

   // assertions
   a_data_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_DATA |-> rsp_out_byte == 8'd0)
      else $error("non-data response carries a byte");
   a_copy_nonzero: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_COPY && seq_ff == SQ_IDLE |-> copy_ff != 32'd0)
      else $error("copy phase with nothing to copy");
   a_offset_range: assert property (@(posedge clock) disable iff (reset)
      lastoff_ff != '0 && {15'd0, lastoff_ff} <= WindowBytes)
      else $error("offset out of window");
   a_read_seq: assert property (@(posedge clock) disable iff (reset)
      seq_ff == SQ_READ |=> seq_ff == SQ_COPY)
      else $error("history read not followed by copy");
endmodule

// ----- test/lz_gamma_stream_decompressor_test.sv -----
// Testbench for lz_gamma_stream_decompressor: builds LZ gamma streams (some end
// in errors), checks every response against a cycle-free decoder model. Uses lzg_pkg.
module lz_gamma_stream_decompressor_test;
   import lzg_pkg::*;

   // what the stream encoder emits next
   localparam int BODY_LIT    = 0;
   localparam int BODY_NEWOFF = 1;
   localparam int BODY_REP    = 2;
   localparam int BODY_NONE   = 3;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic       cmd;
      logic [7:0] data;
      logic       typed;
      logic [1:0] kind;
      logic [7:0] out;
      logic [1:0] status;
   } row_type;

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_cmd = 0, rsp_ready = 0;
   logic [7:0] req_in_byte = 0;
   logic req_ready, rsp_valid;
   logic [1:0] rsp_kind, rsp_status;
   logic [7:0] rsp_out_byte;

   lz_gamma_stream_decompressor uut (.*);

   initial forever #6 clock = ~clock;

   // ---------------- decoder model ----------------
   phase_type   dec_phase;
   logic [7:0]  dec_bits;
   int unsigned dec_nbits;
   logic [31:0] dec_gamma, dec_lits, dec_copy;
   logic [16:0] dec_last;
   logic [7:0]  dec_hist [WindowBytes];
   logic [15:0] dec_wp;

   function automatic logic [31:0] gamma_now();
      return (dec_gamma != 0) ? dec_gamma : 32'd1;
   endfunction

   function automatic void gamma_shift(logic b, phase_type nxt);
      logic [31:0] g;
      g = gamma_now();
      if (g[31]) begin
         dec_phase = PH_ERROR;
      end else begin
         dec_gamma = {g[30:0], b};
         dec_phase = nxt;
      end
   endfunction

   function automatic void decode_bit(logic b);
      logic [31:0] g;
      g = gamma_now();
      case (dec_phase)
         PH_LITLEN_STOP: begin
            if (b) begin
               dec_lits = g; dec_gamma = 0; dec_phase = PH_LITERAL;
            end else dec_phase = PH_LITLEN_DATA;
         end
         PH_LITLEN_DATA: gamma_shift(b, PH_LITLEN_STOP);
         PH_AFTER_LIT:   dec_phase = b ? PH_OFFHI_STOP : PH_REP_STOP;
         PH_CMD:         dec_phase = b ? PH_OFFHI_STOP : PH_LITLEN_STOP;
         PH_OFFHI_STOP: begin
            if (!b) dec_phase = PH_OFFHI_DATA;
            else if (g == EndMark) begin
               dec_gamma = 0; dec_phase = PH_DONE;
            end else begin
               dec_gamma = g - 1; dec_phase = PH_OFFLO;
            end
         end
         PH_OFFHI_DATA:  gamma_shift(b, PH_OFFHI_STOP);
         PH_MLEN_STOP: begin
            if (b) begin
               dec_gamma = 0;
               if (g == 32'hFFFF_FFFF) dec_phase = PH_ERROR;
               else begin
                  dec_copy = g + 1; dec_phase = PH_COPY;
               end
            end else dec_phase = PH_MLEN_DATA;
         end
         PH_MLEN_DATA:   gamma_shift(b, PH_MLEN_STOP);
         PH_REP_STOP: begin
            if (b) begin
               dec_copy = g; dec_gamma = 0; dec_phase = PH_COPY;
            end else dec_phase = PH_REP_DATA;
         end
         PH_REP_DATA:    gamma_shift(b, PH_REP_STOP);
         default: ;
      endcase
   endfunction

   function automatic void drain_flags();
      logic b;
      while (dec_nbits > 0 && dec_phase <= PH_REP_DATA &&
             dec_phase != PH_LITERAL && dec_phase != PH_OFFLO) begin
         b = dec_bits[7];
         dec_bits = dec_bits << 1;
         dec_nbits--;
         decode_bit(b);
      end
   endfunction

   function automatic void hist_write(logic [7:0] v);
      dec_hist[dec_wp] = v;
      dec_wp++;
   endfunction

   function automatic rsp_type decode_request(logic cmd, logic [7:0] data);
      rsp_type r;
      logic [16:0] off;
      logic [63:0] far;
      r = '{KIND_NONE, 8'd0, ST_NEED};
      if (dec_phase == PH_DONE || dec_phase >= PH_ERROR) begin
         r.kind = KIND_REJ;
      end else if (cmd == CMD_DRAIN) begin
         if (dec_phase != PH_COPY) r.kind = KIND_REJ;
         else begin
            off = dec_last;
            if (off == 0 || off > WindowBytes) off = 1;
            r.data = dec_hist[dec_wp - off[15:0]];
            hist_write(r.data);
            r.kind = KIND_DATA;
            dec_copy--;
            if (dec_copy == 0) begin
               dec_phase = PH_CMD;
               drain_flags();
            end
         end
      end else if (dec_phase == PH_COPY) begin
         r.kind = KIND_REJ;
      end else if (dec_phase == PH_LITERAL) begin
         r.data = data;
         hist_write(data);
         r.kind = KIND_DATA;
         dec_lits--;
         if (dec_lits == 0) dec_phase = PH_AFTER_LIT;
         drain_flags();
      end else if (dec_phase == PH_OFFLO) begin
         far = ({32'd0, dec_gamma} << 7 | (127 - (data >> 1))) + 1;
         dec_gamma = 0;
         if (far > WindowBytes) dec_phase = PH_ERROR;
         else begin
            dec_last = far[16:0];
            if (data[0]) begin
               dec_copy = 2; dec_phase = PH_COPY;
            end else dec_phase = PH_MLEN_DATA;
         end
         drain_flags();
      end else begin
         dec_bits = data;
         dec_nbits = 8;
         drain_flags();
      end
      if (dec_phase == PH_DONE) r.status = ST_DONE;
      else if (dec_phase == PH_COPY) r.status = ST_COPY;
      else if (dec_phase >= PH_ERROR) r.status = ST_ERROR;
      return r;
   endfunction

   // ---------------- stream encoder ----------------
   logic [7:0] stream_q [$];
   int flag_at = -1, flag_free = 0;
   int next_body = BODY_LIT;
   int produced = 10;          // bytes output by the directed stretch

   function automatic void put_bit(logic b);
      if (flag_free == 0) begin
         stream_q.push_back(8'd0);
         flag_at = stream_q.size() - 1;
         flag_free = 8;
      end
      stream_q[flag_at][flag_free-1] = b;
      flag_free--;
   endfunction

   // interleaved gamma; skip_lead drops the first continue bit (match length)
   function automatic void put_gamma(logic [31:0] v, bit skip_lead);
      int n;
      n = 31;
      while (!v[n]) n--;
      for (int i = n - 1; i >= 0; i--) begin
         if (!(skip_lead && i == n - 1)) put_bit(0);
         put_bit(v[i]);
      end
      put_bit(1);
   endfunction

   function automatic void put_offset(int o);
      put_gamma(((o - 1) >> 7) + 1, 1'b0);
      stream_q.push_back(8'((127 - ((o - 1) & 127)) << 1));
   endfunction

   function automatic void put_command();
      int n, o;
      case (next_body)
         BODY_LIT: begin
            n = ($urandom_range(9) == 0) ? $urandom_range(300, 7) : $urandom_range(6, 1);
            put_gamma(n, 1'b0);
            repeat (n) stream_q.push_back(8'($urandom));
            produced += n;
            next_body = $urandom_range(1) ? BODY_NEWOFF : BODY_REP;
            put_bit(next_body == BODY_NEWOFF);
         end
         BODY_NEWOFF: begin
            o = $urandom_range($urandom_range(1) ? 8 : 3000, 1);
            if (o > produced) o = produced;
            n = ($urandom_range(9) == 0) ? $urandom_range(100, 21) : $urandom_range(20, 2);
            put_offset(o);
            if (n == 2) stream_q[$][0] = 1'b1;
            else put_gamma(n - 1, 1'b1);
            produced += n;
            next_body = $urandom_range(4) < 3 ? BODY_LIT : BODY_NEWOFF;
            put_bit(next_body == BODY_NEWOFF);
         end
         default: begin
            n = ($urandom_range(9) == 0) ? $urandom_range(80, 9) : $urandom_range(8, 1);
            put_gamma(n, 1'b0);
            produced += n;
            next_body = $urandom_range(4) < 3 ? BODY_LIT : BODY_NEWOFF;
            put_bit(next_body == BODY_NEWOFF);
         end
      endcase
   endfunction

   // end the stream: end marker, or one of the error paths
   function automatic void put_terminator();
      int pick;
      while (next_body == BODY_REP) put_command();
      pick = $urandom_range(3);
      if (next_body == BODY_LIT) begin
         repeat (32) begin       // gamma overflows on the 32nd shift
            put_bit(0); put_bit(1);
         end
      end else if (pick <= 1) begin
         put_gamma(EndMark, 1'b0);
      end else if (pick == 2) begin
         put_gamma(513, 1'b0);   // offset past the window
         stream_q.push_back(8'($urandom));
      end else begin
         put_offset(1);          // length code all ones
         put_bit(1);
         repeat (30) begin
            put_bit(0); put_bit(1);
         end
         put_bit(1);
      end
      flag_free = 0;
      next_body = BODY_NONE;
   endfunction

   // ---------------- checking ----------------
   rsp_type expected_q [$];
   int errors = 0;
   rsp_type got, want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got = '{rsp_kind, rsp_out_byte, rsp_status};
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %h", got);
         end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch: kind %0d/%0d byte %h/%h status %0d/%0d (exp/got)",
                           want.kind, got.kind, want.data, got.data,
                           want.status, got.status);
            end
         end
      end
   end

   // ---------------- response side ----------------
   bit quiet = 0, long_hold = 0;

   initial begin
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_ready <= 0;
            repeat (300) @(posedge clock);
            long_hold = 0;
         end else if (!quiet && $urandom_range(7) == 0) begin
            rsp_ready <= 0;
            repeat ($urandom_range(19, 1)) @(posedge clock);
         end else begin
            rsp_ready <= 1;
            @(posedge clock);
         end
      end
   end

   // ---------------- request side ----------------
   // one request: optional idle burst, then hold until accepted
   task automatic send(logic cmd, logic [7:0] data, bit typed, rsp_type typed_rsp);
      rsp_type r;
      if (!quiet && $urandom_range(7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(19, 1)) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_in_byte <= data;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      r = decode_request(cmd, data);
      expected_q.push_back(typed ? typed_rsp : r);
   endtask

   // pick the next request from the model's phase and the encoded stream
   task automatic send_next();
      if (dec_phase == PH_COPY) begin
         if ($urandom_range(15) == 0) send(CMD_BYTE, 8'($urandom), 1'b0, '0);
         else send(CMD_DRAIN, 8'($urandom), 1'b0, '0);
      end else if ($urandom_range(31) == 0 || stream_q.size() == 0) begin
         send(CMD_DRAIN, 8'($urandom), 1'b0, '0);
      end else begin
         send(CMD_BYTE, stream_q.pop_front(), 1'b0, '0);
         flag_at--;
      end
   endtask

   // hand-encoded opening: literals 00 FF, match at offset 2, rep matches,
   // one-byte literal runs; wrong commands in both directions
   row_type opening [15] = '{
      '{CMD_DRAIN, 8'h00, 1, KIND_REJ,  8'h00, ST_NEED},   // drain with nothing pending
      '{CMD_BYTE,  8'h3A, 0, 0, 0, 0},
      '{CMD_BYTE,  8'h00, 1, KIND_DATA, 8'h00, ST_NEED},
      '{CMD_BYTE,  8'hFF, 0, 0, 0, 0},
      '{CMD_BYTE,  8'hFD, 0, 0, 0, 0},                    // offset 2, length 2
      '{CMD_BYTE,  8'h55, 1, KIND_REJ,  8'h00, ST_COPY},   // byte during copy
      '{CMD_DRAIN, 8'h00, 1, KIND_DATA, 8'h00, ST_COPY},
      '{CMD_DRAIN, 8'hFF, 0, 0, 0, 0},
      '{CMD_BYTE,  8'h80, 0, 0, 0, 0},
      '{CMD_BYTE,  8'h6A, 0, 0, 0, 0},                    // rep length 3
      '{CMD_DRAIN, 8'h00, 0, 0, 0, 0},
      '{CMD_DRAIN, 8'h00, 0, 0, 0, 0},
      '{CMD_DRAIN, 8'h00, 0, 0, 0, 0},
      '{CMD_BYTE,  8'h01, 0, 0, 0, 0},
      '{CMD_DRAIN, 8'h00, 0, 0, 0, 0}
   };

   initial begin
      dec_phase = PH_LITLEN_STOP;
      dec_bits = 0; dec_nbits = 0; dec_gamma = 0; dec_lits = 0;
      dec_last = 1; dec_copy = 0; dec_wp = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      foreach (opening[i])
         send(opening[i].cmd, opening[i].data, opening[i].typed,
              '{opening[i].kind, opening[i].out, opening[i].status});

      for (int n = 0; n < 500; n++) begin
         while (stream_q.size() < 2 || (flag_at == 0 && flag_free > 0)) put_command();
         if (n == 150) long_hold = 1;         // response side stalls, input backs up
         if (n == 300) begin                  // let the block run dry
            req_valid <= 0;
            while (expected_q.size() != 0) @(posedge clock);
         end
         if (n == 430) quiet = 1;
         send_next();
      end
      put_terminator();
      while (stream_q.size() != 0 || dec_phase == PH_COPY) send_next();
      repeat (6) send(1'($urandom_range(1)), 8'($urandom), 1'b0, '0);   // all rejected now
      req_valid <= 0;

      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #(12 * 400000);
      $display("DONE: errors detected");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/lzg_pkg.sv
design/lz_gamma_stream_decompressor.sv
test/lz_gamma_stream_decompressor_test.sv
